>>> hdl/assert_macros.svh
// Assertion helpers for the RTL files; included by vgfps_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, quiet while reset is high.
`define ASSERT_CLK(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("assertion failed");

// Property checked on every rising edge, reset cycles included.
`define ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("assertion failed");

`endif

>>> hdl/vgfps_pkg.sv
package vgfps_pkg;

  // Occupancy store size and id handling.
  localparam int MAX_CELLS      = 65536;
  localparam int VERTEX_ID_BITS = 20;
  localparam int CELL_AW        = $clog2(MAX_CELLS);
  localparam int SAMPLE_ID_W    = 20;
  localparam int CELL_INDEX_W   = 16;
  localparam int DIM_W          = 11;

  localparam logic [33:0] CELL_LIMIT = 34'(MAX_CELLS);
  localparam logic [CELL_AW-1:0] CELL_LAST = CELL_AW'(MAX_CELLS - 1);
  localparam logic [SAMPLE_ID_W-1:0] ID_MASK =
    (VERTEX_ID_BITS >= SAMPLE_ID_W) ? {SAMPLE_ID_W{1'b1}} :
    SAMPLE_ID_W'((64'd1 << VERTEX_ID_BITS) - 64'd1);

  // Request kinds carried on the input tuser bit.
  localparam logic REQ_VERTEX = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    CFG_CORNER_X = 3'd0,
    CFG_CORNER_Y = 3'd1,
    CFG_CORNER_Z = 3'd2,
    CFG_INV_CELL = 3'd3,
    CFG_DIM_X    = 3'd4,
    CFG_DIM_Y    = 3'd5,
    CFG_DIM_Z    = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_AX_MUL,
    ST_AX_ACC,
    ST_IDX_A,
    ST_IDX_B,
    ST_RD,
    ST_TEST,
    ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_in;
    logic clr_step;
    logic ax_mul;
    logic ax_acc;
    logic idx_a;
    logic idx_b;
    logic test;
    logic load_out;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_clear;
    logic clr_last;
    logic ax_last;
    logic oog_final;
    logic out_valid;
  } dp_sts_t;

endpackage

>>> hdl/vgfps_ram.sv
module vgfps_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/vgfps_ctrl.sv
`include "assert_macros.svh"

module vgfps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  input  vgfps_pkg::dp_sts_t  sts,
  output vgfps_pkg::ctl_cmd_t cmd
);

  vgfps_pkg::state_t state;
  vgfps_pkg::state_t state_next;
  logic              clr_reply;
  logic              out_free;

  assign out_free = !sts.out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vgfps_pkg::ST_CLEAR;
      clr_reply <= 1'b0;
    end else begin
      state <= state_next;
      if (state == vgfps_pkg::ST_IDLE && in_valid && sts.in_clear) begin
        clr_reply <= 1'b1;
      end else if (state == vgfps_pkg::ST_CLEAR && sts.clr_last) begin
        clr_reply <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      vgfps_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = sts.in_clear ? vgfps_pkg::ST_CLEAR : vgfps_pkg::ST_AX_MUL;
        end
      end
      vgfps_pkg::ST_CLEAR: begin
        if (sts.clr_last) begin
          state_next = clr_reply ? vgfps_pkg::ST_DONE : vgfps_pkg::ST_IDLE;
        end
      end
      vgfps_pkg::ST_AX_MUL: state_next = vgfps_pkg::ST_AX_ACC;
      vgfps_pkg::ST_AX_ACC: begin
        state_next = sts.ax_last ? vgfps_pkg::ST_IDX_A : vgfps_pkg::ST_AX_MUL;
      end
      vgfps_pkg::ST_IDX_A: state_next = vgfps_pkg::ST_IDX_B;
      vgfps_pkg::ST_IDX_B: state_next = vgfps_pkg::ST_RD;
      vgfps_pkg::ST_RD: begin
        state_next = sts.oog_final ? vgfps_pkg::ST_DONE : vgfps_pkg::ST_TEST;
      end
      vgfps_pkg::ST_TEST: state_next = vgfps_pkg::ST_DONE;
      vgfps_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = vgfps_pkg::ST_IDLE;
        end
      end
      default: state_next = vgfps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      vgfps_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_in  = in_valid;
      end
      vgfps_pkg::ST_CLEAR:  cmd.clr_step = 1'b1;
      vgfps_pkg::ST_AX_MUL: cmd.ax_mul   = 1'b1;
      vgfps_pkg::ST_AX_ACC: cmd.ax_acc   = 1'b1;
      vgfps_pkg::ST_IDX_A:  cmd.idx_a    = 1'b1;
      vgfps_pkg::ST_IDX_B:  cmd.idx_b    = 1'b1;
      vgfps_pkg::ST_TEST:   cmd.test     = 1'b1;
      vgfps_pkg::ST_DONE:   cmd.load_out = out_free;
      default: begin
      end
    endcase
  end

  // A result is never loaded over one that is still waiting.
  `ASSERT_CLK(a_load_free, clk, rst, cmd.load_out |-> (!sts.out_valid || out_ready))
  // The bitmap is only tested right after its read cycle.
  `ASSERT_CLK(a_test_after_rd, clk, rst,
    (state == vgfps_pkg::ST_TEST) |-> ($past(state) == vgfps_pkg::ST_RD))
  // The clearing sweep ends on its last entry.
  `ASSERT_CLK(a_clear_ends, clk, rst,
    (state == vgfps_pkg::ST_CLEAR && sts.clr_last) |=> (state != vgfps_pkg::ST_CLEAR))
  // An accepted request always leaves the idle state.
  `ASSERT_CLK(a_accept_leaves, clk, rst,
    (in_valid && in_ready) |=> (state != vgfps_pkg::ST_IDLE))

endmodule

>>> hdl/vgfps_dp.sv
module vgfps_dp (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  // input request fields
  input  logic                req_type,
  input  logic [19:0]         vertex_id,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  // result fields
  input  logic                out_ready,
  output logic                out_valid,
  output logic [19:0]         sample_id,
  output logic                selected,
  output logic [15:0]         cell_index,
  output logic                out_of_grid,
  output logic                clear_done,
  // control
  input  vgfps_pkg::ctl_cmd_t cmd,
  output vgfps_pkg::dp_sts_t  sts
);

  // Configuration registers.
  logic signed [31:0] corner_x, corner_y, corner_z;
  logic [31:0]        inv_cell_size;
  logic [10:0]        dim_x, dim_y, dim_z;

  // Latched request.
  logic               is_clear;
  logic [19:0]        vid;
  logic signed [31:0] px, py, pz;

  // Per-axis arithmetic.
  logic [1:0]         ax;
  logic [63:0]        prod;
  logic               prod_hi;
  logic               neg_bad;
  logic [10:0]        coord [3];
  logic               oog;
  logic [22:0]        t1;
  logic [33:0]        cell_lin;
  logic               sel;

  logic [vgfps_pkg::CELL_AW-1:0] clear_pointer;

  logic signed [31:0] pos_sel, corner_sel;
  logic [10:0]        dim_sel;
  logic [32:0]        diff;
  logic [32:0]        d;
  logic [32:0]        c;
  logic               oog_final;

  logic                          ram_we;
  logic [vgfps_pkg::CELL_AW-1:0] ram_waddr;
  logic                          ram_wdata;
  logic                          ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_x      <= '0;
      corner_y      <= '0;
      corner_z      <= '0;
      inv_cell_size <= 32'd65536;
      dim_x         <= 11'd1;
      dim_y         <= 11'd1;
      dim_z         <= 11'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        vgfps_pkg::CFG_CORNER_X: corner_x      <= cfg_data;
        vgfps_pkg::CFG_CORNER_Y: corner_y      <= cfg_data;
        vgfps_pkg::CFG_CORNER_Z: corner_z      <= cfg_data;
        vgfps_pkg::CFG_INV_CELL: inv_cell_size <= cfg_data;
        vgfps_pkg::CFG_DIM_X:    dim_x         <= cfg_data[10:0];
        vgfps_pkg::CFG_DIM_Y:    dim_y         <= cfg_data[10:0];
        vgfps_pkg::CFG_DIM_Z:    dim_z         <= cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (ax)
      2'd0: begin
        pos_sel = px; corner_sel = corner_x; dim_sel = dim_x;
      end
      2'd1: begin
        pos_sel = py; corner_sel = corner_y; dim_sel = dim_y;
      end
      default: begin
        pos_sel = pz; corner_sel = corner_z; dim_sel = dim_z;
      end
    endcase
  end

  // Exact difference; below the corner the product is forced to zero.
  assign diff = {pos_sel[31], pos_sel} - {corner_sel[31], corner_sel};
  assign d    = diff[32] ? 33'd0 : diff;
  // floor(d * inv / 2^32) with d split into bit 32 and the low word.
  assign c    = {1'b0, prod[63:32]} + (prod_hi ? {1'b0, inv_cell_size} : 33'd0);

  assign oog_final = oog || (cell_lin >= vgfps_pkg::CELL_LIMIT);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      is_clear <= (req_type == vgfps_pkg::REQ_CLEAR);
      vid      <= vertex_id;
      px       <= pos_x;
      py       <= pos_y;
      pz       <= pos_z;
    end
    if (cmd.ax_mul) begin
      prod    <= {32'd0, d[31:0]} * {32'd0, inv_cell_size};
      prod_hi <= d[32];
      neg_bad <= diff[32] && (inv_cell_size != 32'd0);
    end
    if (cmd.ax_acc) begin
      coord[ax] <= c[10:0];
    end
    if (cmd.idx_a) begin
      t1 <= {1'b0, ({11'd0, coord[0]} * {11'd0, dim_y})} + {12'd0, coord[1]};
    end
    if (cmd.idx_b) begin
      cell_lin <= ({11'd0, t1} * {23'd0, dim_z}) + {23'd0, coord[2]};
    end
    if (cmd.test) begin
      sel <= !ram_rdata;
    end
    if (cmd.load_out) begin
      sample_id   <= vid & vgfps_pkg::ID_MASK;
      selected    <= !is_clear && !oog_final && sel;
      cell_index  <= (is_clear || oog_final) ? 16'd0 : cell_lin[15:0];
      out_of_grid <= !is_clear && oog_final;
      clear_done  <= is_clear;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ax            <= '0;
      oog           <= 1'b0;
      clear_pointer <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        ax  <= '0;
        oog <= 1'b0;
      end else if (cmd.ax_acc) begin
        ax  <= ax + 2'd1;
        oog <= oog || neg_bad || (c >= {22'd0, dim_sel});
      end
      if (cmd.clr_step) begin
        clear_pointer <= (clear_pointer == vgfps_pkg::CELL_LAST) ? '0 : clear_pointer + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign ram_we    = cmd.clr_step || (cmd.test && !ram_rdata);
  assign ram_waddr = cmd.clr_step ? clear_pointer : cell_lin[vgfps_pkg::CELL_AW-1:0];
  assign ram_wdata = !cmd.clr_step;

  vgfps_ram #(
    .WIDTH (1),
    .DEPTH (vgfps_pkg::MAX_CELLS)
  ) u_occ (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cell_lin[vgfps_pkg::CELL_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts           = '0;
    sts.in_clear  = (req_type == vgfps_pkg::REQ_CLEAR);
    sts.clr_last  = (clear_pointer == vgfps_pkg::CELL_LAST);
    sts.ax_last   = (ax == 2'd2);
    sts.oog_final = oog_final;
    sts.out_valid = out_valid;
  end

endmodule

>>> hdl/voxel_grid_first_point_sampler.sv
// A vertex request passes through the shared per-axis multiplier (a multiply step and an
// accumulate step per axis), the index steps and the bitmap read-test-write into the output
// register; one outside the grid skips the bitmap test. A clear request sweeps the whole
// bitmap before its result is loaded. A new request is taken only once the last is loaded.
// Reset: synchronous, active high; it loads the configuration defaults and then runs a
// clearing pass over all MAX_CELLS entries of the occupancy bitmap before the first request.
module voxel_grid_first_point_sampler (
  input  logic         clk,
  input  logic         rst,
  // Request channel.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,  // vertex_id[19:0], pos_x, pos_y, pos_z, zero pad
  input  logic         s_axis_tuser,  // req_type
  // Result channel.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,  // sample_id[19:0], selected, cell_index[15:0],
                                      // out_of_grid, zero pad
  output logic         m_axis_tuser,  // clear_done
  // Configuration write port.
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  // The controller walks each request through its steps; the datapath holds the grid
  // configuration, the per-axis arithmetic, the occupancy bitmap and the result register.
  // The result register frees the request side as soon as a result is loaded, so a new
  // request is taken while the previous result still waits on the result channel.

  vgfps_pkg::ctl_cmd_t cmd;
  vgfps_pkg::dp_sts_t  sts;

  logic [19:0] sample_id;
  logic        selected;
  logic [15:0] cell_index;
  logic        out_of_grid;

  vgfps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Each axis coordinate is floor((pos - corner) * inv_cell_size / 2^32), taken from an
  // exact 33-bit difference and a 32x32 product; the cell index is then built with two
  // small multiplies. A vertex is selected when its bitmap entry was still empty.
  vgfps_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_type    (s_axis_tuser),
    .vertex_id   (s_axis_tdata[19:0]),
    .pos_x       (s_axis_tdata[51:20]),
    .pos_y       (s_axis_tdata[83:52]),
    .pos_z       (s_axis_tdata[115:84]),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .sample_id   (sample_id),
    .selected    (selected),
    .cell_index  (cell_index),
    .out_of_grid (out_of_grid),
    .clear_done  (m_axis_tuser),
    .cmd         (cmd),
    .sts         (sts)
  );

  assign m_axis_tdata = {2'b00, out_of_grid, cell_index, selected, sample_id};

endmodule
